[src/windowed_history_average_max_top_macros.svh]
// Assertion macros shared by the checker of the windowed history block.
`ifndef WINDOWED_HISTORY_AVERAGE_MAX_TOP_MACROS_SVH
`define WINDOWED_HISTORY_AVERAGE_MAX_TOP_MACROS_SVH

// Same-cycle implication, sampled at the rising clock edge outside reset.
`define WHAM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("wham assertion failed");

// Next-cycle implication, sampled at the rising clock edge outside reset.
`define WHAM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("wham assertion failed");

`endif

[src/wham_pkg.sv]
// Package with the types and constants of the windowed history average and maximum block.
package wham_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int COUNT_W   = 7;
  localparam int SUM_W     = 23;
  localparam int DCNT_W    = 5;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_HISTORY_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AVG_WINDOW    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_WINDOW    = 2'd2;

  localparam logic [COUNT_W-1:0] HISTORY_LIMIT_RESET = 7'd64;
  localparam logic [COUNT_W-1:0] AVG_WINDOW_RESET    = 7'd8;
  localparam logic [COUNT_W-1:0] MAX_WINDOW_RESET    = 7'd8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRITE,
    ST_SETUP,
    ST_WALK,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic capture;
    logic write;
    logic setup;
    logic walk;
    logic div_init;
    logic div_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic walk_done;
    logic div_done;
    logic out_free;
  } status_t;

endpackage

[src/wham_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module wham_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[src/wham_ctrl.sv]
// Controller state machine that sequences write, walk, divide and result load.
module wham_ctrl import wham_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  status_t status,
  output cmd_t    cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_next  = ST_WRITE;
        end
      end
      ST_WRITE: begin
        cmd.write  = 1'b1;
        state_next = ST_SETUP;
      end
      ST_SETUP: begin
        cmd.setup  = 1'b1;
        state_next = ST_WALK;
      end
      ST_WALK: begin
        if (status.walk_done) begin
          cmd.div_init = 1'b1;
          state_next   = ST_DIV;
        end else begin
          cmd.walk = 1'b1;
        end
      end
      ST_DIV: begin
        if (status.div_done) begin
          state_next = ST_DONE;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_DONE: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[src/wham_datapath.sv]
// Datapath with configuration, history RAM, window walk, serial divider and result register.
module wham_datapath import wham_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  cmd_t                       cmd,
  output status_t                    status,
  input  logic                       cfg_write_enable,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [COUNT_W-1:0]         cfg_data,
  input  logic signed [SAMPLE_W-1:0] sample_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] window_average,
  output logic signed [SAMPLE_W-1:0] window_maximum,
  output logic [COUNT_W-1:0]         samples_held
);

  localparam int AW = $clog2(DEPTH);
  localparam int CAP = (DEPTH < 127) ? DEPTH : 127;
  localparam logic [COUNT_W-1:0] CAP_COUNT = COUNT_W'(CAP);
  localparam logic [AW-1:0] LAST_SLOT = AW'(DEPTH - 1);
  localparam logic [DCNT_W-1:0] DIV_STEPS = DCNT_W'(SUM_W);

  logic [COUNT_W-1:0] history_limit;
  logic [COUNT_W-1:0] avg_window;
  logic [COUNT_W-1:0] max_window;

  logic signed [SAMPLE_W-1:0] sample;
  logic [AW-1:0]              newest_slot;
  logic [AW-1:0]              slot_next;
  logic [COUNT_W-1:0]         held_count;
  logic [COUNT_W-1:0]         limit_eff;
  logic [COUNT_W:0]           held_inc;

  logic [COUNT_W-1:0] avg_clamp;
  logic [COUNT_W-1:0] max_clamp;
  logic [COUNT_W-1:0] n_avg;
  logic [COUNT_W-1:0] n_max;
  logic [COUNT_W-1:0] n_walk;

  logic [AW-1:0]              rd_addr;
  logic [SAMPLE_W-1:0]        rd_data;
  logic [COUNT_W-1:0]         issue_count;
  logic                       rd_valid;
  logic [COUNT_W-1:0]         rd_k;
  logic                       issue;
  logic signed [SUM_W-1:0]    sum;
  logic signed [SAMPLE_W-1:0] best;
  logic signed [SAMPLE_W-1:0] rd_sample;

  logic [COUNT_W:0]    rem;
  logic [SUM_W-1:0]    quo;
  logic                neg;
  logic [DCNT_W-1:0]   div_count;
  logic [COUNT_W:0]    trial;
  logic [SAMPLE_W-1:0] mean;

  always_ff @(posedge clk) begin
    if (rst) begin
      history_limit <= HISTORY_LIMIT_RESET;
      avg_window    <= AVG_WINDOW_RESET;
      max_window    <= MAX_WINDOW_RESET;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_HISTORY_LIMIT: history_limit <= cfg_data;
        REG_AVG_WINDOW:    avg_window    <= cfg_data;
        REG_MAX_WINDOW:    max_window    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    if (history_limit == '0) begin
      limit_eff = COUNT_W'(1);
    end else if (history_limit > CAP_COUNT) begin
      limit_eff = CAP_COUNT;
    end else begin
      limit_eff = history_limit;
    end
    slot_next = (newest_slot == LAST_SLOT) ? '0 : newest_slot + AW'(1);
    held_inc  = {1'b0, held_count} + (COUNT_W+1)'(1);
    avg_clamp = (avg_window == '0) ? COUNT_W'(1) : avg_window;
    max_clamp = (max_window == '0) ? COUNT_W'(1) : max_window;
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample <= sample_value;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      newest_slot <= '0;
      held_count  <= '0;
    end else if (cmd.write) begin
      newest_slot <= slot_next;
      held_count  <= (held_inc > {1'b0, limit_eff}) ? limit_eff : held_inc[COUNT_W-1:0];
    end
  end

  wham_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (DEPTH)
  ) u_history (
    .clk   (clk),
    .we    (cmd.write),
    .waddr (slot_next),
    .wdata (sample),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign issue     = cmd.walk && (issue_count < n_walk);
  assign rd_sample = rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_valid <= 1'b0;
    end else if (cmd.setup) begin
      rd_valid <= 1'b0;
    end else begin
      rd_valid <= issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      n_avg       <= (avg_clamp > held_count) ? held_count : avg_clamp;
      n_max       <= (max_clamp > held_count) ? held_count : max_clamp;
      n_walk      <= ((avg_clamp > held_count) ? held_count : avg_clamp) >
                     ((max_clamp > held_count) ? held_count : max_clamp) ?
                     ((avg_clamp > held_count) ? held_count : avg_clamp) :
                     ((max_clamp > held_count) ? held_count : max_clamp);
      rd_addr     <= newest_slot;
      issue_count <= '0;
      sum         <= '0;
      best        <= '0;
    end else begin
      if (issue) begin
        rd_addr     <= (rd_addr == '0) ? LAST_SLOT : rd_addr - AW'(1);
        issue_count <= issue_count + COUNT_W'(1);
        rd_k        <= issue_count;
      end
      if (rd_valid) begin
        if (rd_k < n_avg) begin
          sum <= sum + SUM_W'(rd_sample);
        end
        if ((rd_k < n_max) && ((rd_k == '0) || (rd_sample > best))) begin
          best <= rd_sample;
        end
      end
    end
  end

  assign status.walk_done = (issue_count == n_walk) && !rd_valid;

  assign trial = {rem[COUNT_W-1:0], quo[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem       <= '0;
      quo       <= sum[SUM_W-1] ? SUM_W'(-sum) : SUM_W'(sum);
      neg       <= sum[SUM_W-1];
      div_count <= '0;
    end else if (cmd.div_step) begin
      div_count <= div_count + DCNT_W'(1);
      if (trial >= {1'b0, n_avg}) begin
        rem <= trial - {1'b0, n_avg};
        quo <= {quo[SUM_W-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign status.div_done = (div_count == DIV_STEPS);
  assign mean = neg ? SAMPLE_W'(-quo[SAMPLE_W-1:0]) : quo[SAMPLE_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      window_average <= mean;
      window_maximum <= best;
      samples_held   <= held_count;
    end
  end

  assign status.out_free = !out_valid || out_ready;

endmodule

[src/windowed_history_average_max_top.sv]
// Top level of the windowed history average and maximum block.
// Each request pushes one signed 16-bit sample into a circular history of DEPTH
// entries and yields one result: the truncated mean of the newest avg_window
// samples, the largest of the newest max_window samples, and the samples held,
// with both windows clamped to the held count. A result is formed by a walk
// over the newest n entries of the history, where n is the larger clamped
// window, through the single read port of the RAM, one entry a cycle, and by
// the 23-step restoring divider that forms the mean. The block accepts one
// request at a time; a finished result waits in the output register while the
// next request is taken. The history RAM needs no clearing after reset.
module windowed_history_average_max_top import wham_pkg::*; #(
  parameter int DEPTH = 64
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write_enable,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [COUNT_W-1:0]         cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic signed [SAMPLE_W-1:0] sample_value,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [SAMPLE_W-1:0] window_average,
  output logic signed [SAMPLE_W-1:0] window_maximum,
  output logic [COUNT_W-1:0]         samples_held
);

  cmd_t    cmd;
  status_t status;

  wham_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .status   (status),
    .cmd      (cmd)
  );

  wham_datapath #(
    .DEPTH (DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .sample_value     (sample_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .window_average   (window_average),
    .window_maximum   (window_maximum),
    .samples_held     (samples_held)
  );

endmodule

[src/wham_checker.sv]
// Port-level checker for the windowed history block and its bind statement.
`include "windowed_history_average_max_top_macros.svh"

module wham_checker import wham_pkg::*; (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [SAMPLE_W-1:0] window_average,
  input logic signed [SAMPLE_W-1:0] window_maximum,
  input logic [COUNT_W-1:0]         samples_held
);

  // A stalled result keeps its value.
  `WHAM_ASSERT_NEXT(a_result_holds, out_valid && !out_ready,
    out_valid && $stable(window_average) && $stable(window_maximum) && $stable(samples_held))

  // Every result follows a push, so the history is never empty.
  `WHAM_ASSERT_NOW(a_held_nonzero, out_valid, samples_held != '0)

  // The block works on one request at a time.
  `WHAM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready)

endmodule

bind windowed_history_average_max_top wham_checker u_wham_checker (
  .clk            (clk),
  .rst            (rst),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .window_average (window_average),
  .window_maximum (window_maximum),
  .samples_held   (samples_held)
);

[dv/windowed_history_average_max_top_tb.sv]
// Testbench for the windowed history average and maximum block, with its own predictor.
module windowed_history_average_max_top_tb;
  import wham_pkg::*;

  localparam int HIST_DEPTH = 64;
  localparam int CYCLE_LIMIT = 800000;
  localparam int LONG_HOLD = 600;
  localparam int HOLD_AFTER_RESULTS = 150;
  localparam int RANDOM_ITEMS = 1300;
  localparam int QUIET_FROM = 1100;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;

  typedef struct {
    logic signed [SAMPLE_W-1:0] average;
    logic signed [SAMPLE_W-1:0] peak;
    logic [COUNT_W-1:0]         held;
  } window_stats_t;

  class window_stats_board;
    logic signed [SAMPLE_W-1:0] history [HIST_DEPTH];
    logic [5:0]                 newest;
    logic [COUNT_W-1:0]         held;
    logic [COUNT_W-1:0]         limit_reg;
    logic [COUNT_W-1:0]         avg_reg;
    logic [COUNT_W-1:0]         max_reg;
    window_stats_t              expected_stats [$];
    int                         mismatches;

    function new();
      newest = '0;
      held = '0;
      limit_reg = HISTORY_LIMIT_RESET;
      avg_reg = AVG_WINDOW_RESET;
      max_reg = MAX_WINDOW_RESET;
      mismatches = 0;
      foreach (history[i]) history[i] = '0;
    endfunction

    function int clamp(int v, int hi);
      if (v < 1) v = 1;
      if (v > hi) v = hi;
      return v;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [COUNT_W-1:0] val);
      case (idx)
        REG_HISTORY_LIMIT: limit_reg = val;
        REG_AVG_WINDOW: avg_reg = val;
        REG_MAX_WINDOW: max_reg = val;
        default: ;
      endcase
    endfunction

    function void push_sample(logic signed [SAMPLE_W-1:0] v);
      int lim;
      int count;
      int navg;
      int nmax;
      int sum;
      int mean;
      int best;
      logic [5:0] slot;
      window_stats_t s;
      lim = clamp(int'(limit_reg), HIST_DEPTH);
      newest = newest + 6'd1;
      history[newest] = v;
      count = int'(held) + 1;
      if (count > lim) count = lim;
      held = count[COUNT_W-1:0];
      navg = clamp(int'(avg_reg), count);
      nmax = clamp(int'(max_reg), count);
      sum = 0;
      for (int k = 0; k < navg; k++) begin
        slot = newest - 6'(k);
        sum += int'(history[slot]);
      end
      mean = sum / navg;
      best = int'(history[newest]);
      for (int k = 1; k < nmax; k++) begin
        slot = newest - 6'(k);
        if (int'(history[slot]) > best) best = int'(history[slot]);
      end
      s.average = mean[SAMPLE_W-1:0];
      s.peak = best[SAMPLE_W-1:0];
      s.held = held;
      expected_stats.insert(expected_stats.size(), s);
    endfunction

    function void check_result(logic signed [SAMPLE_W-1:0] average,
                               logic signed [SAMPLE_W-1:0] peak,
                               logic [COUNT_W-1:0] held_now);
      window_stats_t s;
      if (expected_stats.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: avg %0d max %0d held %0d", average, peak, held_now);
        return;
      end
      s = expected_stats[0];
      expected_stats.delete(0);
      if (s.average !== average || s.peak !== peak || s.held !== held_now) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected avg %0d max %0d held %0d, got avg %0d max %0d held %0d",
                   s.average, s.peak, s.held, average, peak, held_now);
      end
    endfunction

    function int pending();
      return expected_stats.size();
    endfunction
  endclass

  logic                       clk;
  logic                       rst;
  logic                       cfg_write_enable;
  logic [CFG_IDX_W-1:0]       cfg_index;
  logic [COUNT_W-1:0]         cfg_data;
  logic                       in_valid;
  logic                       in_ready;
  logic signed [SAMPLE_W-1:0] sample_value;
  logic                       out_valid;
  logic                       out_ready;
  logic signed [SAMPLE_W-1:0] window_average;
  logic signed [SAMPLE_W-1:0] window_maximum;
  logic [COUNT_W-1:0]         samples_held;

  window_stats_board board = new();
  bit quiet = 1'b0;
  int cycle_count = 0;
  int results_seen = 0;
  int ready_hold = 0;
  bit long_hold_done = 1'b0;
  int random_sent = 0;

  windowed_history_average_max_top #(.DEPTH(HIST_DEPTH)) uut (
    .clk(clk),
    .rst(rst),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sample_value(sample_value),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .window_average(window_average),
    .window_maximum(window_maximum),
    .samples_held(samples_held)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        board.check_result(window_average, window_maximum, samples_held);
        results_seen++;
      end
      if (!long_hold_done && results_seen == HOLD_AFTER_RESULTS) begin
        long_hold_done = 1'b1;
        ready_hold = LONG_HOLD;
      end
      if (ready_hold == 0 && !quiet && $urandom_range(0, 5) == 0)
        ready_hold = $urandom_range(1, 8);
      if (ready_hold > 0) begin
        out_ready <= 1'b0;
        ready_hold--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [COUNT_W-1:0] val);
    cfg_write_enable <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    board.write_reg(idx, val);
  endtask

  task automatic end_writes();
    cfg_write_enable <= 1'b0;
  endtask

  task automatic sender_gap();
    int n;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send_sample(input logic signed [SAMPLE_W-1:0] v);
    sender_gap();
    in_valid <= 1'b1;
    sample_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    board.push_sample(v);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return 16'($urandom_range(0, 31)) - 16'd16;
      3: return 16'sh7FFF - 16'($urandom_range(0, 255));
      4: return 16'sh8000 + 16'($urandom_range(0, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [COUNT_W-1:0] pick_reg();
    case ($urandom_range(0, 5))
      0: return 7'($urandom_range(0, 2));
      1: return 7'($urandom_range(62, 66));
      2: return 7'($urandom_range(65, 127));
      default: return 7'($urandom_range(1, 64));
    endcase
  endfunction

  initial begin
    int phase_len;
    rst <= 1'b1;
    cfg_write_enable <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    in_valid <= 1'b0;
    sample_value <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    send_sample(16'sh7FFF);
    send_sample(16'sh7FFF);
    send_sample(16'sh8000);
    send_sample(16'sh8000);
    send_sample(-16'sd1);
    send_sample(16'sd1);
    drain();

    write_reg(REG_HISTORY_LIMIT, 7'd0);
    write_reg(REG_AVG_WINDOW, 7'd0);
    write_reg(REG_MAX_WINDOW, 7'd0);
    end_writes();
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    send_sample(16'sd0);
    drain();

    write_reg(REG_HISTORY_LIMIT, 7'd127);
    write_reg(REG_AVG_WINDOW, 7'd127);
    write_reg(REG_MAX_WINDOW, 7'd100);
    write_reg(REG_UNUSED, 7'd5);
    end_writes();
    send_sample(-16'sd7);
    send_sample(16'sd3);
    send_sample(16'sh8000);
    send_sample(16'sd4);
    drain();

    write_reg(REG_HISTORY_LIMIT, 7'd3);
    write_reg(REG_AVG_WINDOW, 7'd64);
    write_reg(REG_MAX_WINDOW, 7'd2);
    end_writes();
    send_sample(-16'sd2);
    send_sample(-16'sd3);
    drain();

    while (random_sent < RANDOM_ITEMS) begin
      write_reg(REG_HISTORY_LIMIT, pick_reg());
      write_reg(REG_AVG_WINDOW, pick_reg());
      write_reg(REG_MAX_WINDOW, pick_reg());
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, 7'($urandom));
      end_writes();
      phase_len = $urandom_range(60, 140);
      for (int i = 0; i < phase_len && random_sent < RANDOM_ITEMS; i++) begin
        if (random_sent >= QUIET_FROM) quiet = 1'b1;
        send_sample(pick_sample());
        random_sent++;
      end
      drain();
    end

    repeat (100) @(posedge clk);
    if (board.pending() != 0) $display("%0d results never arrived", board.pending());
    if (board.mismatches == 0 && board.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/wham_pkg.sv
src/wham_ram.sv
src/wham_ctrl.sv
src/wham_datapath.sv
src/windowed_history_average_max_top.sv
src/wham_checker.sv
dv/windowed_history_average_max_top_tb.sv
